>>> design/ppbw_pkg.sv
// shared widths, result codes and defaults for the packet-pair bandwidth estimator
package ppbw_pkg;

  localparam int KEY_W    = 48;
  localparam int BLK_W    = 32;
  localparam int FRAG_W   = 8;
  localparam int TIME_W   = 48;
  localparam int BYTES_W  = 16;
  localparam int EST_W    = 36;
  localparam int STATUS_W = 3;
  localparam int SCALE_W  = 20;

  localparam logic [SCALE_W-1:0] USEC_PER_SEC = SCALE_W'(1000000);

  localparam int HOSTS_DEF = 16;
  localparam int DEPTH_DEF = 256;

  localparam logic [STATUS_W-1:0] ST_NEW  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REC  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EST  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DROP = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD  = 3'd4;

endpackage

>>> design/ppbw_div.sv
// iterative restoring divider, one quotient bit per cycle
module ppbw_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [ppbw_pkg::EST_W-1:0]  dividend,
  input  logic [ppbw_pkg::TIME_W-1:0] divisor,
  output logic                      done,
  output logic [ppbw_pkg::EST_W-1:0]  quotient
);
  import ppbw_pkg::*;

  localparam int CNT_W = $clog2(EST_W + 1);

  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic              running;
  logic [TIME_W:0]   shifted;
  logic              fits;

  assign shifted = {rem, quotient[EST_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running  <= 1'b1;
        cnt      <= CNT_W'(EST_W);
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (running) begin
        if (fits) begin
          rem <= TIME_W'(shifted - {1'b0, dvs});
        end else begin
          rem <= shifted[TIME_W-1:0];
        end
        quotient <= {quotient[EST_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/ppbw_ring.sv
// per-host estimate ring memory with reset sweep and per-row clear
module ppbw_ring #(
  parameter int SLOT_W = 4,
  parameter int POS_W  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic                     clr_start,
  input  logic [SLOT_W-1:0]        slot,
  input  logic [POS_W-1:0]         pos,
  input  logic [ppbw_pkg::EST_W-1:0] data,
  output logic                     busy
);
  import ppbw_pkg::*;

  localparam int ADDR_W = SLOT_W + POS_W;
  localparam int ENTRIES = 1 << ADDR_W;

  logic [EST_W-1:0] mem [ENTRIES];
  logic [ADDR_W:0]  sweep;
  logic [ADDR_W:0]  sweep_end;
  logic             clearing;

  assign busy = clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      sweep     <= '0;
      sweep_end <= (ADDR_W+1)'(ENTRIES);
    end else if (clearing) begin
      sweep <= sweep + 1'b1;
      if (sweep + 1'b1 == sweep_end) begin
        clearing <= 1'b0;
      end
    end else if (clr_start) begin
      // clear one host row
      clearing  <= 1'b1;
      sweep     <= {1'b0, slot, {POS_W{1'b0}}};
      sweep_end <= {1'b0, slot, {POS_W{1'b0}}} + (ADDR_W+1)'(1 << POS_W);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[sweep[ADDR_W-1:0]] <= '0;
    end else if (wr_en) begin
      mem[{slot, pos}] <= data;
    end
  end

endmodule

>>> design/per_host_packet_pair_bandwidth_top.sv
// top level: host table search, pair check and estimate sequencer
// each table slot compared takes S_RD and S_CMP; a new host or a full table ends in S_RD,
// a known host adds S_LOAD and S_CHK, and an estimate then S_GO and S_DIV; one fragment is handled at a time
// new host: the host's ring row (2**POS_W entries) is cleared afterwards, one a cycle
// reset: synchronous; table empties and the whole ring is cleared
// results are strobed on done for one cycle, the receiver cannot stall
module per_host_packet_pair_bandwidth_top #(
  parameter int HOSTS          = ppbw_pkg::HOSTS_DEF,
  parameter int ESTIMATE_DEPTH = ppbw_pkg::DEPTH_DEF,
  parameter int SLOT_W         = (HOSTS > 1) ? $clog2(HOSTS) : 1,
  parameter int POS_W          = $clog2(ESTIMATE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ppbw_pkg::KEY_W-1:0]    host_key,
  input  logic [ppbw_pkg::BLK_W-1:0]    block_id,
  input  logic [ppbw_pkg::FRAG_W-1:0]   fragment_index,
  input  logic [ppbw_pkg::TIME_W-1:0]   arrival_time_us,
  input  logic [ppbw_pkg::BYTES_W-1:0]  fragment_bytes,
  output logic                          done,
  output logic [ppbw_pkg::STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]             host_slot,
  output logic [ppbw_pkg::EST_W-1:0]    estimate,
  output logic [POS_W-1:0]              estimate_slot
);
  import ppbw_pkg::*;

  localparam int CNT_W = $clog2(HOSTS + 1);
  localparam int REC_W = BLK_W + FRAG_W + TIME_W + POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_GO   = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;

  logic [2:0]         state;
  logic [CNT_W-1:0]   hosts_in_use;
  logic [CNT_W-1:0]   idx;

  logic [KEY_W-1:0]   key_mem [HOSTS];
  logic [REC_W-1:0]   rec_mem [HOSTS];
  logic [KEY_W-1:0]   key_q;
  logic [REC_W-1:0]   rec_q;

  logic [KEY_W-1:0]   key_r;
  logic [BLK_W-1:0]   blk_r;
  logic [FRAG_W-1:0]  frag_r;
  logic [TIME_W-1:0]  now_r;
  logic [BYTES_W-1:0] bytes_r;
  logic [EST_W-1:0]   dividend;
  logic [TIME_W-1:0]  delta;
  logic [POS_W-1:0]   pos_r;

  logic [BLK_W-1:0]   last_blk;
  logic [FRAG_W-1:0]  last_frag;
  logic [TIME_W-1:0]  last_time;
  logic [POS_W-1:0]   last_pos;
  logic               paired;
  logic [POS_W-1:0]   pos_inc;

  logic               div_done;
  logic [EST_W-1:0]   quotient;
  logic               ring_busy;
  logic               ring_wr;
  logic               ring_clr;
  logic [SLOT_W-1:0]  slot;

  assign {last_blk, last_frag, last_time, last_pos} = rec_q;
  assign paired  = (last_blk == blk_r) &&
                   ({1'b0, last_frag} + 9'd1 == {1'b0, frag_r});
  assign pos_inc = (pos_r == POS_W'(ESTIMATE_DEPTH - 1)) ? '0 : pos_r + 1'b1;
  assign slot    = idx[SLOT_W-1:0];
  assign busy    = (state != S_IDLE) || ring_busy;
  assign ring_wr = div_done && (state == S_DIV);
  assign ring_clr = (state == S_RD) && (idx == hosts_in_use) &&
                    (hosts_in_use != CNT_W'(HOSTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      hosts_in_use <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start && !busy) begin
            key_r   <= host_key;
            blk_r   <= block_id;
            frag_r  <= fragment_index;
            now_r   <= arrival_time_us;
            bytes_r <= fragment_bytes;
            idx     <= '0;
            state   <= S_RD;
          end
        end
        S_RD: begin
          if (idx == hosts_in_use) begin
            done          <= 1'b1;
            estimate      <= '0;
            estimate_slot <= '0;
            state         <= S_IDLE;
            if (hosts_in_use == CNT_W'(HOSTS)) begin
              status    <= ST_DROP;
              host_slot <= '0;
            end else begin
              status       <= ST_NEW;
              host_slot    <= slot;
              hosts_in_use <= hosts_in_use + 1'b1;
            end
          end else begin
            key_q <= key_mem[slot];
            state <= S_CMP;
          end
        end
        S_CMP: begin
          if (key_q == key_r) begin
            state <= S_LOAD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_LOAD: begin
          rec_q <= rec_mem[slot];
          state <= S_CHK;
        end
        S_CHK: begin
          pos_r    <= last_pos;
          delta    <= now_r - last_time;
          dividend <= EST_W'(bytes_r) * EST_W'(USEC_PER_SEC);
          if (paired && (now_r > last_time)) begin
            state <= S_GO;
          end else begin
            done          <= 1'b1;
            status        <= paired ? ST_BAD : ST_REC;
            host_slot     <= slot;
            estimate      <= '0;
            estimate_slot <= '0;
            state         <= S_IDLE;
          end
        end
        S_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            done          <= 1'b1;
            status        <= ST_EST;
            host_slot     <= slot;
            estimate      <= quotient;
            estimate_slot <= pos_r;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // table writes: key and first record on allocation, record update on every hit
  always_ff @(posedge clk) begin
    if (ring_clr) begin
      key_mem[slot] <= key_r;
      rec_mem[slot] <= {blk_r, frag_r, now_r, {POS_W{1'b0}}};
    end else if (state == S_CHK) begin
      rec_mem[slot] <= {blk_r, frag_r, now_r, last_pos};
    end else if (ring_wr) begin
      rec_mem[slot] <= {blk_r, frag_r, now_r, pos_inc};
    end
  end

  ppbw_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (state == S_GO),
    .dividend (dividend),
    .divisor  (delta),
    .done     (div_done),
    .quotient (quotient)
  );

  ppbw_ring #(
    .SLOT_W (SLOT_W),
    .POS_W  (POS_W)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (ring_wr),
    .clr_start (ring_clr),
    .slot      (slot),
    .pos       (pos_r),
    .data      (quotient),
    .busy      (ring_busy)
  );

endmodule

>>> design/ppbw_chk.sv
// port-level checks for the bandwidth estimator, bound to the top level
module ppbw_chk #(
  parameter int SLOT_W = 4,
  parameter int POS_W  = 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [ppbw_pkg::STATUS_W-1:0] status,
  input logic [SLOT_W-1:0]             host_slot,
  input logic [ppbw_pkg::EST_W-1:0]    estimate,
  input logic [POS_W-1:0]              estimate_slot
);
  import ppbw_pkg::*;

  a_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_NEW || status == ST_REC || status == ST_EST ||
              status == ST_DROP || status == ST_BAD))
    else $error("unknown status code");

  a_no_est: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_EST |-> estimate == '0 && estimate_slot == '0)
    else $error("estimate fields set without an estimate");

  a_drop: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_DROP |-> host_slot == '0)
    else $error("dropped beat carries a slot");

  a_take: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not make the block busy");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a beat in flight");

endmodule

bind per_host_packet_pair_bandwidth_top ppbw_chk #(
  .SLOT_W (SLOT_W),
  .POS_W  (POS_W)
) u_ppbw_chk (.*);
